// File: sv/fpha_pkg.sv
// ----------------------------------------------------------------------------
// fpha_pkg
// Shared types and constants for the fit-policy heap allocator.
// ----------------------------------------------------------------------------
package fpha_pkg;

	localparam int HEAP_BYTES   = 4096;
	localparam int HEADER_BYTES = 16;
	localparam int MAX_SEGMENTS = 256;

	localparam int AW = 13;                       // byte offset / size width
	localparam int IW = $clog2(MAX_SEGMENTS);     // table index width
	localparam int CW = $clog2(MAX_SEGMENTS + 1); // segment count width

	typedef enum logic [1:0] {
		POL_FIRST = 2'd0,
		POL_NEXT  = 2'd1,
		POL_BEST  = 2'd2,
		POL_WORST = 2'd3
	} policy_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NULL  = 2'd1,
		ST_FAULT = 2'd2
	} status_t;

	typedef struct packed {
		logic [AW-1:0] start;
		logic [AW-1:0] size;
		logic          is_free;
	} seg_t;

	// request context held for the duration of a table scan
	typedef struct packed {
		opcode_t       op;
		policy_t       policy;
		logic [AW-1:0] req_size;
		logic [AW-1:0] free_address;
		logic [AW-1:0] rover;
	} pick_req_t;

	typedef struct packed {
		logic          vld;
		logic [IW-1:0] idx;
		seg_t          seg;
	} cand_t;

endpackage

// File: sv/fpha_ram.sv
// ----------------------------------------------------------------------------
// fpha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fpha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/fpha_pick.sv
// ----------------------------------------------------------------------------
// fpha_pick
// Segment selector: consumes the table one entry a cycle while ent_vld is
// high and keeps the fit-policy candidate, or the matching entry for a free.
// ----------------------------------------------------------------------------
module fpha_pick (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clear,
	input  fpha_pkg::pick_req_t        req,
	input  logic                       ent_vld,
	input  logic [fpha_pkg::IW-1:0]    ent_idx,
	input  fpha_pkg::seg_t             ent,
	output fpha_pkg::cand_t            pick
);

	fpha_pkg::cand_t           cand_a_q;
	fpha_pkg::cand_t           cand_b_q; // lowest fit overall, wrap case of next fit
	logic [fpha_pkg::AW-1:0]   bound_q;
	fpha_pkg::cand_t           new_c;
	logic                      fits;
	logic                      hit;

	always_comb begin
		new_c.vld = 1'b1;
		new_c.idx = ent_idx;
		new_c.seg = ent;
		fits = ent.is_free && (ent.size >= req.req_size);
		hit  = (ent.start + fpha_pkg::AW'(fpha_pkg::HEADER_BYTES) == req.free_address) &&
		       (req.free_address < fpha_pkg::AW'(fpha_pkg::HEAP_BYTES));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_a_q <= '0;
			cand_b_q <= '0;
			bound_q  <= '0;
		end else if (clear) begin
			cand_a_q.vld <= 1'b0;
			cand_b_q.vld <= 1'b0;
			bound_q <= (req.policy == fpha_pkg::POL_BEST) ?
			           fpha_pkg::AW'(fpha_pkg::HEAP_BYTES - fpha_pkg::HEADER_BYTES) :
			           req.req_size;
		end else if (ent_vld) begin
			if (req.op == fpha_pkg::OP_FREE) begin
				if (hit && !cand_a_q.vld) begin
					cand_a_q <= new_c;
				end
			end else begin
				case (req.policy)
					fpha_pkg::POL_FIRST: begin
						if (fits && !cand_a_q.vld) begin
							cand_a_q <= new_c;
						end
					end
					fpha_pkg::POL_NEXT: begin
						// entries up to the rover form a prefix; restart the search there
						if (ent.start <= req.rover) begin
							cand_a_q <= {fits, ent_idx, ent};
						end else if (fits && !cand_a_q.vld) begin
							cand_a_q <= new_c;
						end
						if (fits && !cand_b_q.vld) begin
							cand_b_q <= new_c;
						end
					end
					fpha_pkg::POL_BEST: begin
						if (fits && ent.size <= bound_q) begin
							bound_q  <= ent.size;
							cand_a_q <= new_c;
						end
					end
					default: begin
						// the request size is the bound until a candidate exists
						if (ent.is_free &&
						    ent.size > (cand_a_q.vld ? bound_q : req.req_size)) begin
							bound_q  <= ent.size;
							cand_a_q <= new_c;
						end
					end
				endcase
			end
		end
	end

	assign pick = (req.op == fpha_pkg::OP_ALLOC && req.policy == fpha_pkg::POL_NEXT &&
	               !cand_a_q.vld) ? cand_b_q : cand_a_q;

endmodule

// File: sv/fpha_merge.sv
// ----------------------------------------------------------------------------
// fpha_merge
// Table rebuilder: takes the edited segment stream in address order,
// coalesces adjacent free segments and writes the result compacted.
// ----------------------------------------------------------------------------
module fpha_merge (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    clear,
	input  logic                    item_vld,
	input  fpha_pkg::seg_t          item,
	input  logic                    flush,
	output logic                    wr_en,
	output logic [fpha_pkg::IW-1:0] wr_addr,
	output fpha_pkg::seg_t          wr_data,
	output logic [fpha_pkg::CW-1:0] wr_count
);

	logic                    pend_vld_q;
	fpha_pkg::seg_t          pend_q;
	logic [fpha_pkg::CW-1:0] widx_q;
	logic                    join_c;

	assign join_c  = pend_vld_q && pend_q.is_free && item.is_free;
	assign wr_en   = pend_vld_q && ((item_vld && !join_c) || flush);
	assign wr_addr = widx_q[fpha_pkg::IW-1:0];
	assign wr_data = pend_q;
	assign wr_count = widx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			widx_q     <= '0;
		end else if (clear) begin
			pend_vld_q <= 1'b0;
			widx_q     <= '0;
		end else if (item_vld) begin
			if (join_c) begin
				pend_q.size <= pend_q.size + item.size + fpha_pkg::AW'(fpha_pkg::HEADER_BYTES);
			end else begin
				if (pend_vld_q) begin
					widx_q <= widx_q + 1'b1;
				end
				pend_q     <= item;
				pend_vld_q <= 1'b1;
			end
		end else if (flush && pend_vld_q) begin
			widx_q     <= widx_q + 1'b1;
			pend_vld_q <= 1'b0;
		end
	end

endmodule

// File: sv/fit_policy_heap_allocator.sv
// ----------------------------------------------------------------------------
// fit_policy_heap_allocator
// Heap allocator over an address-ordered segment table in two RAM banks.
//
//  channel | dir | handshake              | content
//  s_*     | in  | s_tvalid / s_tready    | request: opcode, size, address
//  m_*     | out | m_tvalid / m_tready    | result: data address, status
//  cfg_*   | in  | cfg_valid / cfg_ready  | fit policy register
//
// A request scans the N-entry table, then successful allocations and
// frees rebuild it into the other bank, leaving a slot for the split-off
// tail on a split; each pass is one RAM read a cycle but for that slot.
// After reset the table reads as one free segment; no clearing pass.
// A result waits in the output register; the next request is taken once
// it has been transferred.
// ----------------------------------------------------------------------------
module fit_policy_heap_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [12:0] req_size, [25:13] free_address
	input  logic [0:0]  s_tuser,  // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [11:0] data_address, [13:12] status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data  // [1:0] fit_policy
);

	localparam int AW = fpha_pkg::AW;
	localparam int IW = fpha_pkg::IW;
	localparam int CW = fpha_pkg::CW;
	localparam int SW = $bits(fpha_pkg::seg_t);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SCAN   = 6'b000010,
		S_DECIDE = 6'b000100,
		S_BUILD  = 6'b001000,
		S_FLUSH  = 6'b010000,
		S_FIN    = 6'b100000
	} state_t;

	state_t               state_q;
	fpha_pkg::policy_t    policy_q;
	fpha_pkg::opcode_t    op_q;
	logic [AW-1:0]        req_q;
	logic [AW-1:0]        addr_q;
	logic [AW-1:0]        rover_q;
	logic [CW-1:0]        count_q;
	logic                 bank_q;   // 0: table in bank A
	logic                 fresh_q;  // table still as after reset
	logic [CW-1:0]        rd_idx_q;
	logic                 bubble_q;
	logic                 rv_s1;
	logic                 inj_s1;
	logic [IW-1:0]        ri_s1;
	logic [IW-1:0]        pidx_q;
	logic                 split_q;
	fpha_pkg::seg_t       mod_q;
	fpha_pkg::seg_t       extra_q;
	logic                 out_vld_q;
	logic [11:0]          data_q;
	fpha_pkg::status_t    status_q;

	logic                 accept;
	logic                 issue;
	logic [IW-1:0]        raddr;
	logic [SW-1:0]        rd_a;
	logic [SW-1:0]        rd_b;
	fpha_pkg::seg_t       fetched;
	fpha_pkg::seg_t       item;
	fpha_pkg::pick_req_t  preq;
	fpha_pkg::cand_t      pick;
	logic                 wr_en;
	logic [IW-1:0]        wr_addr;
	fpha_pkg::seg_t       wr_data;
	logic [CW-1:0]        wr_count;
	logic [AW-1:0]        diff;
	logic                 split_c;
	logic [AW-1:0]        given_c;
	logic [AW:0]          end_c;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE) && !out_vld_q;
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = {2'b00, status_q, data_q};
	assign cfg_ready = 1'b1;

	assign issue = ((state_q == S_SCAN) || (state_q == S_BUILD && !bubble_q)) &&
	               (rd_idx_q < count_q);
	assign raddr = rd_idx_q[IW-1:0];

	fpha_ram #(.WIDTH(SW), .DEPTH(fpha_pkg::MAX_SEGMENTS)) u_bank_a (
		.clk   (clk),
		.we    (wr_en && bank_q),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (raddr),
		.rdata (rd_a)
	);

	fpha_ram #(.WIDTH(SW), .DEPTH(fpha_pkg::MAX_SEGMENTS)) u_bank_b (
		.clk   (clk),
		.we    (wr_en && !bank_q),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (raddr),
		.rdata (rd_b)
	);

	always_comb begin
		// only entry 0 is live while the table is fresh
		if (fresh_q) begin
			fetched.start   = '0;
			fetched.size    = AW'(fpha_pkg::HEAP_BYTES - fpha_pkg::HEADER_BYTES);
			fetched.is_free = 1'b1;
		end else begin
			fetched = bank_q ? fpha_pkg::seg_t'(rd_b) : fpha_pkg::seg_t'(rd_a);
		end
		if (inj_s1) begin
			item = extra_q;
		end else if (ri_s1 == pidx_q) begin
			item = mod_q;
		end else begin
			item = fetched;
		end
	end

	always_comb begin
		preq.op           = op_q;
		preq.policy       = policy_q;
		preq.req_size     = req_q;
		preq.free_address = addr_q;
		preq.rover        = rover_q;
	end

	fpha_pick u_pick (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (state_q == S_IDLE),
		.req     (preq),
		.ent_vld (rv_s1 && state_q == S_SCAN),
		.ent_idx (ri_s1),
		.ent     (fetched),
		.pick    (pick)
	);

	fpha_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (state_q == S_DECIDE),
		.item_vld (rv_s1 && state_q == S_BUILD),
		.item     (item),
		.flush    (state_q == S_FLUSH),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.wr_count (wr_count)
	);

	always_comb begin
		diff    = pick.seg.size - req_q;
		split_c = (diff >= AW'(fpha_pkg::HEADER_BYTES)) &&
		          (count_q < CW'(fpha_pkg::MAX_SEGMENTS));
		given_c = split_c ? req_q : pick.seg.size;
		end_c   = {1'b0, pick.seg.start} + (AW+1)'(fpha_pkg::HEADER_BYTES) + {1'b0, given_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			policy_q  <= fpha_pkg::POL_FIRST;
			rover_q   <= '0;
			count_q   <= CW'(1);
			bank_q    <= 1'b0;
			fresh_q   <= 1'b1;
			rd_idx_q  <= '0;
			bubble_q  <= 1'b0;
			rv_s1     <= 1'b0;
			inj_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				policy_q <= fpha_pkg::policy_t'(cfg_data[1:0]);
			end
			if (m_tvalid && m_tready) begin
				out_vld_q <= 1'b0;
			end

			rv_s1  <= issue || (state_q == S_BUILD && bubble_q);
			inj_s1 <= (state_q == S_BUILD) && bubble_q;
			ri_s1  <= raddr;
			if (issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
				// leave a slot for the split-off tail behind the edited entry
				bubble_q <= (state_q == S_BUILD) && split_q && (raddr == pidx_q);
			end else begin
				bubble_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					rd_idx_q <= '0;
					if (accept) begin
						op_q    <= fpha_pkg::opcode_t'(s_tuser[0]);
						req_q   <= s_tdata[12:0];
						addr_q  <= s_tdata[25:13];
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!issue && !rv_s1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					rd_idx_q <= '0;
					pidx_q   <= pick.idx;
					data_q   <= '0;
					if (op_q == fpha_pkg::OP_ALLOC) begin
						if (req_q == '0 || !pick.vld) begin
							status_q  <= fpha_pkg::ST_NULL;
							out_vld_q <= 1'b1;
							state_q   <= S_IDLE;
						end else begin
							split_q         <= split_c;
							mod_q.start     <= pick.seg.start;
							mod_q.size      <= given_c;
							mod_q.is_free   <= 1'b0;
							extra_q.start   <= pick.seg.start + AW'(fpha_pkg::HEADER_BYTES) + req_q;
							extra_q.size    <= diff - AW'(fpha_pkg::HEADER_BYTES);
							extra_q.is_free <= 1'b1;
							if (policy_q == fpha_pkg::POL_NEXT) begin
								rover_q <= (end_c >= (AW+1)'(fpha_pkg::HEAP_BYTES)) ?
								           '0 : end_c[AW-1:0];
							end
							data_q   <= 12'(pick.seg.start + AW'(fpha_pkg::HEADER_BYTES));
							status_q <= fpha_pkg::ST_OK;
							state_q  <= S_BUILD;
						end
					end else begin
						if (!pick.vld || pick.seg.is_free) begin
							status_q  <= fpha_pkg::ST_FAULT;
							out_vld_q <= 1'b1;
							state_q   <= S_IDLE;
						end else begin
							split_q  <= 1'b0;
							mod_q    <= {pick.seg.start, pick.seg.size, 1'b1};
							status_q <= fpha_pkg::ST_OK;
							state_q  <= S_BUILD;
						end
					end
				end
				S_BUILD: begin
					if (!issue && !bubble_q && !rv_s1) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					count_q   <= wr_count;
					bank_q    <= !bank_q;
					fresh_q   <= 1'b0;
					out_vld_q <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
